@@ rtl/cfd_boundary_ghost_state_unit_macros.svh @@
// Assertion helpers for the boundary ghost unit
`ifndef CFD_BOUNDARY_GHOST_STATE_UNIT_MACROS_SVH
`define CFD_BOUNDARY_GHOST_STATE_UNIT_MACROS_SVH

// same-cycle implication
`define CBG_ASSERT_IMP(label, ante, cons) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error("boundary ghost unit check failed");

// next-cycle implication
`define CBG_ASSERT_NXT(label, ante, cons) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error("boundary ghost unit check failed");

`endif

@@ rtl/cbg_pkg.sv @@
package cbg_pkg;

   localparam int DW = 48;
   localparam int NW = 32;
   localparam int HW = 26;
   localparam int IW = 3;

   typedef logic signed [DW-1:0] q_type;

   typedef enum logic [2:0] {
      MODE_INLET  = 3'd0,
      MODE_COPY   = 3'd1,
      MODE_PRES   = 3'd2,
      MODE_SLIP   = 3'd3,
      MODE_NOSLIP = 3'd4,
      MODE_SYM    = 3'd5
   } mode_type;

   typedef enum logic [IW-1:0] {
      CSR_MODE  = 3'd0,
      CSR_PAR_A = 3'd1,
      CSR_PAR_B = 3'd2,
      CSR_PAR_C = 3'd3,
      CSR_PAR_D = 3'd4,
      CSR_PAR_E = 3'd5,
      CSR_HEAT  = 3'd6
   } csr_type;

   localparam q_type Q_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam q_type Q_MIN = 48'sh8000_0000_0000;
   localparam q_type ONE_Q = 48'sh0000_0100_0000;
   localparam logic [HW-1:0] HEAT_RESET = 26'd23488102;

   // m[48] flags a magnitude at or above 2^48
   function automatic q_type signed_sat(input logic [DW:0] m, input logic neg);
      q_type r;
      if (neg) begin
         if (m[48] || m[47]) r = Q_MIN;
         else r = q_type'(~m[DW-1:0] + 48'd1);
      end else begin
         if (m[48] || m[47]) r = Q_MAX;
         else r = q_type'(m[DW-1:0]);
      end
      return r;
   endfunction

   function automatic q_type sat50(input logic signed [DW+1:0] x);
      q_type r;
      if (x > 50'(Q_MAX)) r = Q_MAX;
      else if (x < 50'(Q_MIN)) r = Q_MIN;
      else r = q_type'(x[DW-1:0]);
      return r;
   endfunction

   function automatic logic [DW-1:0] mag48(input q_type a);
      logic [DW-1:0] r;
      if (a[DW-1]) r = ~a + 48'd1;
      else r = a;
      return r;
   endfunction

endpackage

@@ rtl/cbg_delay.sv @@
module cbg_delay #(
   parameter int W = 48,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] d_ff [N];

   always_ff @(posedge clock) begin
      d_ff[0] <= din;
      for (int i = 1; i < N; i++) begin
         d_ff[i] <= d_ff[i-1];
      end
   end

   assign dout = d_ff[N-1];

endmodule

@@ rtl/cbg_umul48.sv @@
module cbg_umul48 (
   input  logic        clock,
   input  logic [47:0] a,
   input  logic [47:0] b,
   output logic [95:0] p
);

   logic [63:0] ll_ff;
   logic [47:0] lh_ff;
   logic [47:0] hl_ff;
   logic [31:0] hh_ff;
   logic [48:0] mid;
   logic [95:0] p_in;
   logic [95:0] p_ff;

   always_ff @(posedge clock) begin
      ll_ff <= a[31:0] * b[31:0];
      lh_ff <= a[31:0] * b[47:32];
      hl_ff <= a[47:32] * b[31:0];
      hh_ff <= a[47:32] * b[47:32];
   end

   always_comb begin
      mid  = {1'b0, lh_ff} + {1'b0, hl_ff};
      p_in = {hh_ff, 64'd0} + {15'd0, mid, 32'd0} + {32'd0, ll_ff};
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

@@ rtl/cbg_mulrs.sv @@
module cbg_mulrs #(
   parameter int SHIFT = 24
) (
   input  logic          clock,
   input  cbg_pkg::q_type a,
   input  cbg_pkg::q_type b,
   output cbg_pkg::q_type y
);

   localparam logic [95:0] RND = 96'd1 << (SHIFT - 1);

   logic [47:0]    ma_ff;
   logic [47:0]    mb_ff;
   logic           neg_ff;
   logic           neg1_ff;
   logic           neg2_ff;
   logic [95:0]    prod;
   logic [95:0]    sh;
   cbg_pkg::q_type y_in;
   cbg_pkg::q_type y_ff;

   always_ff @(posedge clock) begin
      ma_ff   <= cbg_pkg::mag48(a);
      mb_ff   <= cbg_pkg::mag48(b);
      neg_ff  <= a[47] ^ b[47];
      neg1_ff <= neg_ff;
      neg2_ff <= neg1_ff;
   end

   cbg_umul48 u_mul (
      .clock (clock),
      .a     (ma_ff),
      .b     (mb_ff),
      .p     (prod)
   );

   always_comb begin
      sh   = (prod + RND) >> SHIFT;
      y_in = cbg_pkg::signed_sat({|sh[95:48], sh[47:0]}, neg2_ff);
   end

   always_ff @(posedge clock) begin
      y_ff <= y_in;
   end

   assign y = y_ff;

endmodule

@@ rtl/cbg_div.sv @@
module cbg_div (
   input  logic          clock,
   input  cbg_pkg::q_type num,
   input  cbg_pkg::q_type den,
   output cbg_pkg::q_type quo
);

   localparam int STEPS = 47;

   typedef struct packed {
      logic neg;
      logic zero;
      logic npos;
      logic nneg;
      logic over;
   } div_flag_type;

   logic [47:0]  nm_ff   [STEPS+1];
   logic [47:0]  dm_ff   [STEPS+1];
   logic [47:0]  rem_ff  [STEPS+1];
   logic [46:0]  q_ff    [STEPS+1];
   div_flag_type flag_ff [STEPS+1];

   logic [47:0]  nm;
   logic [47:0]  dm;
   logic         rnd;
   logic [47:0]  qr;
   cbg_pkg::q_type quo_in;
   cbg_pkg::q_type quo_ff;

   assign nm = cbg_pkg::mag48(num);
   assign dm = cbg_pkg::mag48(den);

   always_ff @(posedge clock) begin
      nm_ff[0]        <= nm;
      dm_ff[0]        <= dm;
      rem_ff[0]       <= {23'd0, nm[47:23]};
      q_ff[0]         <= '0;
      flag_ff[0].neg  <= num[47] ^ den[47];
      flag_ff[0].zero <= (den == '0);
      flag_ff[0].npos <= !num[47] && (num != '0);
      flag_ff[0].nneg <= num[47];
      flag_ff[0].over <= {23'd0, nm} >= {dm, 23'd0};
   end

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      localparam int I = STEPS - 1 - j;
      logic        bit_in;
      logic [48:0] trial;
      logic        ge;
      logic [48:0] diff;

      if (I >= 24) begin : g_num
         assign bit_in = nm_ff[j][I-24];
      end else begin : g_pad
         assign bit_in = 1'b0;
      end

      always_comb begin
         trial = {rem_ff[j], bit_in};
         ge    = trial >= {1'b0, dm_ff[j]};
         diff  = trial - {1'b0, dm_ff[j]};
      end

      always_ff @(posedge clock) begin
         nm_ff[j+1]   <= nm_ff[j];
         dm_ff[j+1]   <= dm_ff[j];
         rem_ff[j+1]  <= ge ? diff[47:0] : trial[47:0];
         q_ff[j+1]    <= q_ff[j] | (47'(ge) << I);
         flag_ff[j+1] <= flag_ff[j];
      end
   end

   always_comb begin
      rnd = {rem_ff[STEPS], 1'b0} >= {1'b0, dm_ff[STEPS]};
      qr  = {1'b0, q_ff[STEPS]} + 48'(rnd);
      priority if (flag_ff[STEPS].zero) begin
         if (flag_ff[STEPS].npos) quo_in = cbg_pkg::Q_MAX;
         else if (flag_ff[STEPS].nneg) quo_in = cbg_pkg::Q_MIN;
         else quo_in = '0;
      end else if (flag_ff[STEPS].over) begin
         quo_in = flag_ff[STEPS].neg ? cbg_pkg::Q_MIN : cbg_pkg::Q_MAX;
      end else begin
         quo_in = cbg_pkg::signed_sat({1'b0, qr}, flag_ff[STEPS].neg);
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
   end

   assign quo = quo_ff;

endmodule

@@ rtl/cfd_boundary_ghost_state_unit.sv @@
// Throughput: one face per cycle; busy is set by reset and clears at the first clock edge without reset.
// The latency is set by the inlet density path: a 47-stage restoring divider, one
// quotient bit per stage, behind two 4-stage multipliers.
// Reset: mode returns to outlet copy, parameters to zero, gamma to 1.4; beats in flight drop.
// The receiver cannot stall: each result shows for exactly one cycle.
`include "cfd_boundary_ghost_state_unit_macros.svh"

module cfd_boundary_ghost_state_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic signed [31:0]   req_normal_x,
   input  logic signed [31:0]   req_normal_y,
   input  logic signed [31:0]   req_normal_z,
   input  logic signed [47:0]   req_vel_u,
   input  logic signed [47:0]   req_vel_v,
   input  logic signed [47:0]   req_vel_w,
   input  logic signed [47:0]   req_pressure,
   input  logic signed [47:0]   req_temperature,
   input  logic signed [47:0]   req_density,
   input  logic signed [47:0]   req_energy,
   input  logic signed [47:0]   req_heat_cap_cv,
   input  logic signed [47:0]   req_sound_speed,
   output logic                 rsp_strobe,
   output logic signed [47:0]   rsp_ghost_u,
   output logic signed [47:0]   rsp_ghost_v,
   output logic signed [47:0]   rsp_ghost_w,
   output logic signed [47:0]   rsp_ghost_pressure,
   output logic signed [47:0]   rsp_ghost_temperature,
   output logic signed [47:0]   rsp_ghost_density,
   output logic signed [47:0]   rsp_ghost_energy,
   output logic                 rsp_turb_zero,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [47:0]          csr_wdata
);

   localparam int ST_OUT = 59;

   // configuration
   cbg_pkg::mode_type mode_ff;
   cbg_pkg::q_type    par_a_ff, par_b_ff, par_c_ff, par_d_ff, par_e_ff;
   logic [25:0]       heat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= cbg_pkg::MODE_COPY;
         par_a_ff <= '0;
         par_b_ff <= '0;
         par_c_ff <= '0;
         par_d_ff <= '0;
         par_e_ff <= '0;
         heat_ff  <= cbg_pkg::HEAT_RESET;
      end else if (csr_we) begin
         unique case (cbg_pkg::csr_type'(csr_index))
            cbg_pkg::CSR_MODE:  mode_ff  <= cbg_pkg::mode_type'(csr_wdata[2:0]);
            cbg_pkg::CSR_PAR_A: par_a_ff <= csr_wdata;
            cbg_pkg::CSR_PAR_B: par_b_ff <= csr_wdata;
            cbg_pkg::CSR_PAR_C: par_c_ff <= csr_wdata;
            cbg_pkg::CSR_PAR_D: par_d_ff <= csr_wdata;
            cbg_pkg::CSR_PAR_E: par_e_ff <= csr_wdata;
            cbg_pkg::CSR_HEAT:  heat_ff  <= csr_wdata[25:0];
            default: ;
         endcase
      end
   end

   // handshake and valid pipe
   logic              busy_ff;
   logic              req_acc;
   logic [ST_OUT:1]   vld_ff;

   assign busy    = busy_ff;
   assign req_acc = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         vld_ff  <= '0;
      end else begin
         busy_ff <= 1'b0;
         vld_ff  <= {vld_ff[ST_OUT-1:1], req_acc};
      end
   end

   // stage 1: input capture
   cbg_pkg::q_type vel_ff [3];
   logic [31:0]    n_ff   [3];
   cbg_pkg::q_type p_ff, t_ff, r_ff, e_ff, cv_ff, cz_ff;

   always_ff @(posedge clock) begin
      vel_ff[0] <= req_vel_u;
      vel_ff[1] <= req_vel_v;
      vel_ff[2] <= req_vel_w;
      n_ff[0]   <= req_normal_x;
      n_ff[1]   <= req_normal_y;
      n_ff[2]   <= req_normal_z;
      p_ff      <= req_pressure;
      t_ff      <= req_temperature;
      r_ff      <= req_density;
      e_ff      <= req_energy;
      cv_ff     <= req_heat_cap_cv;
      cz_ff     <= req_sound_speed;
   end

   // normal velocity, stage 6
   cbg_pkg::q_type un_term [3];
   cbg_pkg::q_type un_ff;
   logic [31:0]    n_d6    [3];
   cbg_pkg::q_type vn      [3];

   for (genvar k = 0; k < 3; k++) begin : g_un
      cbg_mulrs #(.SHIFT(30)) u_vn_term (
         .clock (clock),
         .a     (vel_ff[k]),
         .b     ({{16{n_ff[k][31]}}, n_ff[k]}),
         .y     (un_term[k])
      );

      cbg_delay #(.W(32), .N(5)) u_n_dly (
         .clock (clock),
         .din   (n_ff[k]),
         .dout  (n_d6[k])
      );

      cbg_mulrs #(.SHIFT(30)) u_vn (
         .clock (clock),
         .a     ({{16{n_d6[k][31]}}, n_d6[k]}),
         .b     (un_ff),
         .y     (vn[k])
      );
   end

   always_ff @(posedge clock) begin
      un_ff <= cbg_pkg::sat50(50'(un_term[0]) + 50'(un_term[1]) + 50'(un_term[2]));
   end

   // wall velocities, stage 11
   logic [143:0]   vel_d10;
   cbg_pkg::q_type wall_ff [3];
   logic [143:0]   wall_d58;

   cbg_delay #(.W(144), .N(9)) u_vel_dly (
      .clock (clock),
      .din   ({vel_ff[2], vel_ff[1], vel_ff[0]}),
      .dout  (vel_d10)
   );

   for (genvar k = 0; k < 3; k++) begin : g_wall
      cbg_pkg::q_type v10;
      assign v10 = vel_d10[48*k +: 48];
      always_ff @(posedge clock) begin
         if (mode_ff == cbg_pkg::MODE_NOSLIP) begin
            wall_ff[k] <= cbg_pkg::sat50(50'(v10) - 50'(vn[k]));
         end else begin
            wall_ff[k] <= cbg_pkg::sat50(50'(v10) - 50'(vn[k]) - 50'(vn[k]));
         end
      end
   end

   cbg_delay #(.W(144), .N(47)) u_wall_dly (
      .clock (clock),
      .din   ({wall_ff[2], wall_ff[1], wall_ff[0]}),
      .dout  (wall_d58)
   );

   // speed against sound speed, lt at stage 7
   logic [47:0] sqm_ff [4];
   logic [95:0] sq     [4];
   logic [96:0] s01_ff;
   logic [95:0] sq2_ff;
   logic [95:0] c5_ff;
   logic [97:0] s_ff;
   logic [95:0] c6_ff;
   logic        lt_ff;

   always_ff @(posedge clock) begin
      sqm_ff[0] <= cbg_pkg::mag48(vel_ff[0]);
      sqm_ff[1] <= cbg_pkg::mag48(vel_ff[1]);
      sqm_ff[2] <= cbg_pkg::mag48(vel_ff[2]);
      sqm_ff[3] <= cbg_pkg::mag48(cz_ff);
   end

   for (genvar k = 0; k < 4; k++) begin : g_sq
      cbg_umul48 u_sq (
         .clock (clock),
         .a     (sqm_ff[k]),
         .b     (sqm_ff[k]),
         .p     (sq[k])
      );
   end

   always_ff @(posedge clock) begin
      s01_ff <= {1'b0, sq[0]} + {1'b0, sq[1]};
      sq2_ff <= sq[2];
      c5_ff  <= sq[3];
      s_ff   <= {1'b0, s01_ff} + {2'b0, sq2_ff};
      c6_ff  <= c5_ff;
      lt_ff  <= s_ff < {2'b0, c6_ff};
   end

   // pressure outlet, stage 15
   cbg_pkg::q_type un_sq;
   cbg_pkg::q_type r_d10;
   cbg_pkg::q_type dyn;
   logic           un_neg_d14;
   logic           lt_d14;
   cbg_pkg::q_type p_d14;
   cbg_pkg::q_type p_pres_ff;
   cbg_pkg::q_type p_pres_d58;
   logic           un_neg_d58;

   cbg_mulrs #(.SHIFT(24)) u_un_sq (
      .clock (clock),
      .a     (un_ff),
      .b     (un_ff),
      .y     (un_sq)
   );

   cbg_delay #(.W(48), .N(9)) u_r_dly (
      .clock (clock),
      .din   (r_ff),
      .dout  (r_d10)
   );

   cbg_mulrs #(.SHIFT(25)) u_dyn (
      .clock (clock),
      .a     (r_d10),
      .b     (un_sq),
      .y     (dyn)
   );

   cbg_delay #(.W(1), .N(8)) u_neg_dly (
      .clock (clock),
      .din   (un_ff[47]),
      .dout  (un_neg_d14)
   );

   cbg_delay #(.W(1), .N(7)) u_lt_dly (
      .clock (clock),
      .din   (lt_ff),
      .dout  (lt_d14)
   );

   cbg_delay #(.W(48), .N(13)) u_p_dly (
      .clock (clock),
      .din   (p_ff),
      .dout  (p_d14)
   );

   always_ff @(posedge clock) begin
      priority if (un_neg_d14) p_pres_ff <= cbg_pkg::sat50(50'(par_a_ff) - 50'(dyn));
      else if (lt_d14) p_pres_ff <= par_a_ff;
      else p_pres_ff <= p_d14;
   end

   cbg_delay #(.W(48), .N(43)) u_pp_dly (
      .clock (clock),
      .din   (p_pres_ff),
      .dout  (p_pres_d58)
   );

   cbg_delay #(.W(1), .N(52)) u_neg58_dly (
      .clock (clock),
      .din   (un_ff[47]),
      .dout  (un_neg_d58)
   );

   // supersonic inlet: energy at stage 5, density at stage 58
   cbg_pkg::q_type e_in;
   cbg_pkg::q_type e_in_d58;
   cbg_pkg::q_type g1;
   cbg_pkg::q_type den;
   cbg_pkg::q_type r_in;

   assign g1 = cbg_pkg::q_type'({22'd0, heat_ff}) - cbg_pkg::ONE_Q;

   cbg_mulrs #(.SHIFT(24)) u_e_in (
      .clock (clock),
      .a     (cv_ff),
      .b     (par_e_ff),
      .y     (e_in)
   );

   cbg_mulrs #(.SHIFT(24)) u_den (
      .clock (clock),
      .a     (g1),
      .b     (e_in),
      .y     (den)
   );

   cbg_div u_div (
      .clock (clock),
      .num   (par_d_ff),
      .den   (den),
      .quo   (r_in)
   );

   cbg_delay #(.W(48), .N(53)) u_ein_dly (
      .clock (clock),
      .din   (e_in),
      .dout  (e_in_d58)
   );

   // interior state carried to stage 58
   logic [335:0] raw_d58;

   cbg_delay #(.W(336), .N(57)) u_raw_dly (
      .clock (clock),
      .din   ({e_ff, r_ff, t_ff, p_ff, vel_ff[2], vel_ff[1], vel_ff[0]}),
      .dout  (raw_d58)
   );

   // result select, stage 59
   cbg_pkg::q_type o_u, o_v, o_w, o_p, o_t, o_r, o_e;
   logic           o_tz;
   cbg_pkg::q_type out_u_ff, out_v_ff, out_w_ff, out_p_ff, out_t_ff, out_r_ff, out_e_ff;
   logic           out_tz_ff;

   always_comb begin
      o_u  = raw_d58[47:0];
      o_v  = raw_d58[95:48];
      o_w  = raw_d58[143:96];
      o_p  = raw_d58[191:144];
      o_t  = raw_d58[239:192];
      o_r  = raw_d58[287:240];
      o_e  = raw_d58[335:288];
      o_tz = 1'b0;
      unique case (mode_ff)
         cbg_pkg::MODE_INLET: begin
            o_u = par_a_ff;
            o_v = par_b_ff;
            o_w = par_c_ff;
            o_p = par_d_ff;
            o_t = par_e_ff;
            o_r = r_in;
            o_e = e_in_d58;
         end
         cbg_pkg::MODE_PRES: begin
            o_p = p_pres_d58;
            if (un_neg_d58) o_t = par_b_ff;
         end
         cbg_pkg::MODE_SLIP, cbg_pkg::MODE_SYM: begin
            o_u = wall_d58[47:0];
            o_v = wall_d58[95:48];
            o_w = wall_d58[143:96];
         end
         cbg_pkg::MODE_NOSLIP: begin
            o_u  = wall_d58[47:0];
            o_v  = wall_d58[95:48];
            o_w  = wall_d58[143:96];
            o_t  = par_a_ff;
            o_tz = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      out_u_ff <= o_u;
      out_v_ff <= o_v;
      out_w_ff <= o_w;
      out_p_ff <= o_p;
      out_t_ff <= o_t;
      out_r_ff <= o_r;
      out_e_ff <= o_e;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_tz_ff <= 1'b0;
      end else begin
         out_tz_ff <= o_tz && vld_ff[ST_OUT-1];
      end
   end

   assign rsp_strobe            = vld_ff[ST_OUT];
   assign rsp_ghost_u           = out_u_ff;
   assign rsp_ghost_v           = out_v_ff;
   assign rsp_ghost_w           = out_w_ff;
   assign rsp_ghost_pressure    = out_p_ff;
   assign rsp_ghost_temperature = out_t_ff;
   assign rsp_ghost_density     = out_r_ff;
   assign rsp_ghost_energy      = out_e_ff;
   assign rsp_turb_zero         = out_tz_ff;

   `CBG_ASSERT_IMP(a_strobe_src, rsp_strobe, $past(req_acc, ST_OUT))
   `CBG_ASSERT_IMP(a_turb_noslip, rsp_turb_zero, rsp_strobe && $past(mode_ff == cbg_pkg::MODE_NOSLIP))
   `CBG_ASSERT_NXT(a_no_busy, 1'b1, !busy)

endmodule

@@ dv/ghost_state_checker.sv @@
module ghost_state_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [31:0] req_normal_x,
   input  logic signed [31:0] req_normal_y,
   input  logic signed [31:0] req_normal_z,
   input  logic signed [47:0] req_vel_u,
   input  logic signed [47:0] req_vel_v,
   input  logic signed [47:0] req_vel_w,
   input  logic signed [47:0] req_pressure,
   input  logic signed [47:0] req_temperature,
   input  logic signed [47:0] req_density,
   input  logic signed [47:0] req_energy,
   input  logic signed [47:0] req_heat_cap_cv,
   input  logic signed [47:0] req_sound_speed,
   input  logic               rsp_strobe,
   input  logic signed [47:0] rsp_ghost_u,
   input  logic signed [47:0] rsp_ghost_v,
   input  logic signed [47:0] rsp_ghost_w,
   input  logic signed [47:0] rsp_ghost_pressure,
   input  logic signed [47:0] rsp_ghost_temperature,
   input  logic signed [47:0] rsp_ghost_density,
   input  logic signed [47:0] rsp_ghost_energy,
   input  logic               rsp_turb_zero,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_wdata,
   output int                 errors,
   output int                 outstanding,
   output int                 matched
);

   localparam longint MAXP = 64'sh7FFF_FFFF_FFFF;
   localparam longint MINN = -64'sh8000_0000_0000;

   typedef struct {
      logic signed [47:0] u, v, w, p, t, r, e;
      logic               tz;
   } ghost_type;

   logic [2:0]         mode_q;
   logic signed [47:0] pa, pb, pc, pd, pe;
   logic [25:0]        gamma_q;
   ghost_type          expected_ghosts[$];

   function automatic longint clamp48(longint x);
      if (x > MAXP) return MAXP;
      if (x < MINN) return MINN;
      return x;
   endfunction

   function automatic longint clamp_mag(logic [127:0] m, bit neg);
      if (neg) return (m >= 128'h8000_0000_0000) ? MINN : -longint'(m[63:0]);
      return (m > 128'h7FFF_FFFF_FFFF) ? MAXP : longint'(m[63:0]);
   endfunction

   function automatic logic [63:0] abs64(longint a);
      return (a < 0) ? 64'(-a) : 64'(a);
   endfunction

   function automatic logic [127:0] square_mag(longint a);
      return {64'd0, abs64(a)} * {64'd0, abs64(a)};
   endfunction

   // (a*b) >> s, rounded half away from zero, saturated
   function automatic longint scaled_product(longint a, longint b, int s);
      logic [127:0] m;
      bit neg;
      neg = (a < 0) != (b < 0);
      m = {64'd0, abs64(a)} * {64'd0, abs64(b)};
      m = (m + (128'd1 << (s - 1))) >> s;
      return clamp_mag(m, neg);
   endfunction

   // (num << 24) / den, rounded half away from zero, saturated
   function automatic longint scaled_quotient(longint num, longint den);
      logic [127:0] n, d, q, rm;
      bit neg;
      if (den == 0) return (num > 0) ? MAXP : ((num < 0) ? MINN : 0);
      neg = (num < 0) != (den < 0);
      n = {64'd0, abs64(num)} << 24;
      d = {64'd0, abs64(den)};
      q = n / d;
      rm = n % d;
      if (q >= 128'h8000_0000_0000) return neg ? MINN : MAXP;
      if (rm * 2 >= d) q = q + 1;
      return clamp_mag(q, neg);
   endfunction

   function automatic ghost_type ghost_of_face(longint nx, longint ny, longint nz,
         longint u, longint v, longint w, longint p, longint t, longint r,
         longint e, longint cv, longint cs);
      ghost_type g;
      longint  n[3], vel[3], un, vn, g1;
      logic [127:0] s2;
      bit      tz;
      n = '{nx, ny, nz};
      vel = '{u, v, w};
      tz = 0;
      un = clamp48(scaled_product(u, nx, 30) + scaled_product(v, ny, 30)
                   + scaled_product(w, nz, 30));
      case (mode_q)
         cbg_pkg::MODE_INLET: begin
            g1 = longint'(gamma_q) - (64'sd1 <<< 24);
            vel = '{longint'(pa), longint'(pb), longint'(pc)};
            p = pd;
            t = pe;
            e = scaled_product(cv, t, 24);
            r = scaled_quotient(p, scaled_product(g1, e, 24));
         end
         cbg_pkg::MODE_PRES: begin
            if (un < 0) begin
               t = pb;
               p = clamp48(longint'(pa) - scaled_product(r, scaled_product(un, un, 24), 25));
            end else begin
               s2 = square_mag(u) + square_mag(v) + square_mag(w);
               if (s2 < square_mag(cs)) p = pa;
            end
         end
         cbg_pkg::MODE_SLIP, cbg_pkg::MODE_SYM: begin
            for (int k = 0; k < 3; k++) begin
               vn = scaled_product(n[k], un, 30);
               vel[k] = clamp48(vel[k] - vn - vn);
            end
         end
         cbg_pkg::MODE_NOSLIP: begin
            for (int k = 0; k < 3; k++) begin
               vn = scaled_product(n[k], un, 30);
               vel[k] = clamp48(vel[k] - vn);
            end
            t = pa;
            tz = 1;
         end
         default: ;
      endcase
      g.u = vel[0][47:0];
      g.v = vel[1][47:0];
      g.w = vel[2][47:0];
      g.p = p[47:0];
      g.t = t[47:0];
      g.r = r[47:0];
      g.e = e[47:0];
      g.tz = tz;
      return g;
   endfunction

   task automatic check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      ghost_type g;
      if (reset) begin
         mode_q = cbg_pkg::MODE_COPY;
         {pa, pb, pc, pd, pe} = '0;
         gamma_q = cbg_pkg::HEAT_RESET;
         expected_ghosts.delete();
         errors = 0;
         matched = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_ghosts.size() == 0) begin
               $error("result beat with nothing expected");
               errors++;
            end else begin
               g = expected_ghosts.pop_front();
               check_field("ghost_u", g.u, rsp_ghost_u);
               check_field("ghost_v", g.v, rsp_ghost_v);
               check_field("ghost_w", g.w, rsp_ghost_w);
               check_field("ghost_pressure", g.p, rsp_ghost_pressure);
               check_field("ghost_temperature", g.t, rsp_ghost_temperature);
               check_field("ghost_density", g.r, rsp_ghost_density);
               check_field("ghost_energy", g.e, rsp_ghost_energy);
               check_field("turb_zero", 48'(g.tz), 48'(rsp_turb_zero));
               matched++;
            end
         end
         if (start && !busy)
            expected_ghosts.push_back(ghost_of_face(req_normal_x, req_normal_y,
               req_normal_z, req_vel_u, req_vel_v, req_vel_w, req_pressure,
               req_temperature, req_density, req_energy, req_heat_cap_cv,
               req_sound_speed));
         if (csr_we) begin
            case (csr_index)
               cbg_pkg::CSR_MODE:  mode_q = csr_wdata[2:0];
               cbg_pkg::CSR_PAR_A: pa = csr_wdata;
               cbg_pkg::CSR_PAR_B: pb = csr_wdata;
               cbg_pkg::CSR_PAR_C: pc = csr_wdata;
               cbg_pkg::CSR_PAR_D: pd = csr_wdata;
               cbg_pkg::CSR_PAR_E: pe = csr_wdata;
               cbg_pkg::CSR_HEAT:  gamma_q = csr_wdata[25:0];
               default: ;
            endcase
         end
      end
      outstanding = expected_ghosts.size();
   end

endmodule

@@ dv/testbench.sv @@
module testbench;

   localparam int LATENCY = 59;
   localparam int IDLE_LIMIT = 5000;
   localparam int PHASES = 16;

   logic clock, reset, start, busy, csr_we;
   logic signed [31:0] nx, ny, nz;
   logic signed [47:0] u, v, w, p, t, r, e, cv, cs;
   logic rsp_strobe, rsp_turb_zero;
   logic signed [47:0] gu, gv, gw, gp, gt, gr, ge;
   logic [2:0]  csr_index;
   logic [47:0] csr_wdata;
   int errors, outstanding, matched, idle_cycles, faces;

   cfd_boundary_ghost_state_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_normal_x(nx), .req_normal_y(ny), .req_normal_z(nz),
      .req_vel_u(u), .req_vel_v(v), .req_vel_w(w), .req_pressure(p),
      .req_temperature(t), .req_density(r), .req_energy(e),
      .req_heat_cap_cv(cv), .req_sound_speed(cs),
      .rsp_strobe(rsp_strobe), .rsp_ghost_u(gu), .rsp_ghost_v(gv), .rsp_ghost_w(gw),
      .rsp_ghost_pressure(gp), .rsp_ghost_temperature(gt), .rsp_ghost_density(gr),
      .rsp_ghost_energy(ge), .rsp_turb_zero(rsp_turb_zero),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   ghost_state_checker chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_normal_x(nx), .req_normal_y(ny), .req_normal_z(nz),
      .req_vel_u(u), .req_vel_v(v), .req_vel_w(w), .req_pressure(p),
      .req_temperature(t), .req_density(r), .req_energy(e),
      .req_heat_cap_cv(cv), .req_sound_speed(cs),
      .rsp_strobe(rsp_strobe), .rsp_ghost_u(gu), .rsp_ghost_v(gv), .rsp_ghost_w(gw),
      .rsp_ghost_pressure(gp), .rsp_ghost_temperature(gt), .rsp_ghost_density(gr),
      .rsp_ghost_energy(ge), .rsp_turb_zero(rsp_turb_zero),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .outstanding(outstanding), .matched(matched)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired: no beat for %0d cycles", idle_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // kind: 0 max, 1 min, 2 zero, 3 full random, 4 moderate, 5 one
   function automatic logic [47:0] pick_q(int kind);
      case (kind)
         0: return 48'h7FFF_FFFF_FFFF;
         1: return 48'h8000_0000_0000;
         2: return 48'd0;
         3: return 48'({$urandom, $urandom});
         4: return 48'($signed($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000);
         default: return 48'h0000_0100_0000;
      endcase
   endfunction

   function automatic logic [31:0] pick_normal(int kind);
      case (kind)
         0: return 32'h4000_0000;
         1: return 32'hC000_0000;
         2: return 32'd0;
         3: return $urandom;
         4: return 32'($signed($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000);
         default: return 32'h8000_0000;
      endcase
   endfunction

   function automatic int rand_kind();
      int k;
      k = $urandom_range(0, 9);
      return (k < 4) ? 4 : (k < 7 ? 3 : k - 7);
   endfunction

   task automatic write_reg(cbg_pkg::csr_type idx, logic [47:0] data);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic set_phase(int ph);
      logic [25:0] heat;
      case (ph % 5)
         0: heat = 26'd16777217;
         1: heat = 26'd50331648;
         2: heat = cbg_pkg::HEAT_RESET;
         3: heat = 26'd16777216;
         default: heat = 26'($urandom);
      endcase
      write_reg(cbg_pkg::CSR_MODE, 48'(ph % 8));
      write_reg(cbg_pkg::CSR_PAR_A, pick_q(rand_kind()));
      write_reg(cbg_pkg::CSR_PAR_B, pick_q(rand_kind()));
      write_reg(cbg_pkg::CSR_PAR_C, pick_q(rand_kind()));
      write_reg(cbg_pkg::CSR_PAR_D, pick_q(rand_kind()));
      write_reg(cbg_pkg::CSR_PAR_E, pick_q(rand_kind()));
      write_reg(cbg_pkg::CSR_HEAT, {22'd0, heat});
      csr_we <= 0;
   endtask

   task automatic load_face(int kind, bit mixed);
      nx <= pick_normal(mixed ? rand_kind() : kind);
      ny <= pick_normal(mixed ? rand_kind() : kind);
      nz <= pick_normal(mixed ? rand_kind() : kind);
      u  <= pick_q(mixed ? rand_kind() : kind);
      v  <= pick_q(mixed ? rand_kind() : kind);
      w  <= pick_q(mixed ? rand_kind() : kind);
      p  <= pick_q(mixed ? rand_kind() : kind);
      t  <= pick_q(mixed ? rand_kind() : kind);
      r  <= pick_q(mixed ? rand_kind() : kind);
      e  <= pick_q(mixed ? rand_kind() : kind);
      cv <= pick_q(mixed ? rand_kind() : kind);
      cs <= pick_q(mixed ? rand_kind() : kind);
   endtask

   initial begin
      int burst, gap, count;
      reset = 1;
      start = 0;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      {nx, ny, nz} = '0;
      {u, v, w, p, t, r, e, cv, cs} = '0;
      faces = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);
      burst = 1;
      for (int ph = 0; ph < PHASES; ph++) begin
         while (outstanding != 0) @(negedge clock);
         repeat (LATENCY + 3) @(negedge clock);
         set_phase(ph);
         count = (ph == 0) ? 24 : 38;
         for (int i = 0; i < count; i++) begin
            if (--burst <= 0) begin
               burst = $urandom_range(1, 30);
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               if (gap > 0) begin
                  start <= 0;
                  repeat (gap) @(negedge clock);
               end
            end
            // directed faces first, every field of one kind, then faces with a random kind per field
            if (ph == 0 || i < 3) load_face(i % 6, 0);
            else load_face(0, 1);
            start <= 1;
            @(posedge clock);
            while (busy) @(posedge clock);
            faces++;
            @(negedge clock);
         end
         start <= 0;
         @(negedge clock);
      end
      while (outstanding != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
      $display("Sent %0d faces over %0d register settings covering all mode codes;",
               faces, PHASES);
      $display("%0d ghost states checked, %0d errors", matched, errors);
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
